// ===== src/tcw_pkg.sv =====
// Shared types, field widths and constants of the text console writer.
package tcw_pkg;

   localparam int MAX_ROWS_DEF = 32;
   localparam int MAX_COLS_DEF = 128;

   localparam int ACTION_W    = 2;
   localparam int CHAR_W      = 8;
   localparam int TROW_W      = 5;
   localparam int TCOL_W      = 7;
   localparam int OFFSET_W    = 12;
   localparam int CELL_W      = 16;
   localparam int CFG_INDEX_W = 2;
   localparam int CFG_DATA_W  = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_SET   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_ROWS  = 2'd0,
      REG_COLS  = 2'd1,
      REG_ATTR  = 2'd2,
      REG_TRACK = 2'd3
   } reg_index_type;

   localparam logic [5:0]        RESET_ROWS   = 6'd25;
   localparam logic [7:0]        RESET_COLS   = 8'd80;
   localparam logic [7:0]        RESET_ATTR   = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;

   typedef struct packed {
      logic [5:0] rows;
      logic [7:0] cols;
      logic [7:0] attr;
      logic       track;
   } cfg_type;

   typedef struct packed {
      logic [TROW_W-1:0]   cursor_row;
      logic [TCOL_W-1:0]   cursor_col;
      logic [OFFSET_W-1:0] cursor_offset;
      logic                scrolled;
      logic [CELL_W-1:0]   cell_value;
      logic [TROW_W-1:0]   typed_end_row;
      logic [TCOL_W-1:0]   typed_end_col;
   } rsp_payload_type;

endpackage

// ===== src/tcw_channels.sv =====
// Request and response channel interfaces of the text console writer.
interface tcw_req_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   char_code;
   logic [TROW_W-1:0]   target_row;
   logic [TCOL_W-1:0]   target_col;

   modport source (output valid, action, char_code, target_row, target_col, input ready);
   modport sink   (input valid, action, char_code, target_row, target_col, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TROW_W-1:0]   cursor_row;
   logic [TCOL_W-1:0]   cursor_col;
   logic [OFFSET_W-1:0] cursor_offset;
   logic                scrolled;
   logic [CELL_W-1:0]   cell_value;
   logic [TROW_W-1:0]   typed_end_row;
   logic [TCOL_W-1:0]   typed_end_col;

   modport source (output valid, cursor_row, cursor_col, cursor_offset, scrolled,
                   cell_value, typed_end_row, typed_end_col, input ready);
   modport sink   (input valid, cursor_row, cursor_col, cursor_offset, scrolled,
                   cell_value, typed_end_row, typed_end_col, output ready);
endinterface

// ===== src/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module tcw_ram import tcw_pkg::*; #(
   parameter  int WIDTH  = CELL_W,
   parameter  int DEPTH  = MAX_ROWS_DEF * MAX_COLS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tcw_engine.sv =====
// Console engine: cursor state, action sequencer and screen memory sweeps.
module tcw_engine import tcw_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   tcw_req_if.sink  req,
   tcw_rsp_if.source rsp
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int AREA_W = $clog2(DEPTH + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int RC_W   = (RCNT_W > TROW_W) ? RCNT_W : TROW_W;
   localparam int CC_W   = (CCNT_W > TCOL_W) ? CCNT_W : TCOL_W;
   localparam int MUL_W  = ROW_W + CCNT_W;
   localparam int AMUL_W = RCNT_W + CCNT_W;

   typedef enum logic [2:0] {S_INIT, S_IDLE, S_EXEC, S_SWEEP, S_DONE} state_type;

   state_type           state_ff;
   action_type          act_ff;
   logic [CHAR_W-1:0]   ch_ff;
   logic [ROW_W-1:0]    crow_ff, trow_ff, cur_row_ff, end_row_ff;
   logic [COL_W-1:0]    ccol_ff, tcol_ff, cur_col_ff, end_col_ff;
   logic [ADDR_W-1:0]   caddr_ff, taddr_ff;
   logic [AREA_W-1:0]   area_ff;
   logic [ADDR_W-1:0]   cnt_ff, last_ff, pend_addr_ff;
   logic [AREA_W-1:0]   copy_lim_ff;
   logic [CELL_W-1:0]   fill_ff;
   logic                pend_ff, pend_copy_ff;
   rsp_payload_type     rsp_ff, res_ff;
   logic                rsp_valid_ff;

   logic [RCNT_W-1:0]   rows_eff, rows_m1;
   logic [CCNT_W-1:0]   cols_eff, cols_m1;
   logic [ROW_W-1:0]    trow_c, crow_c;
   logic [COL_W-1:0]    tcol_c, ccol_c;
   logic [ADDR_W-1:0]   taddr_c, caddr_c;
   logic [AREA_W-1:0]   area_c;

   logic                accept, out_free, newline, wrap, last_row, scroll, need_sweep;
   logic                exec_we, sweeping, copy, rsp_load;
   logic [ROW_W-1:0]    cur_row_in, end_row_in;
   logic [COL_W-1:0]    cur_col_in, end_col_in;
   logic [AREA_W-1:0]   off_in;
   rsp_payload_type     res_in;
   logic [CELL_W-1:0]   blank;

   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [CELL_W-1:0]   mem_wdata, mem_rdata;

   // effective geometry and clamped positions
   always_comb begin
      if (cfg.rows == '0) begin
         rows_eff = RCNT_W'(1);
      end else if (int'(cfg.rows) > MAX_ROWS) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(cfg.rows);
      end
      if (cfg.cols == '0) begin
         cols_eff = CCNT_W'(1);
      end else if (int'(cfg.cols) > MAX_COLS) begin
         cols_eff = CCNT_W'(MAX_COLS);
      end else begin
         cols_eff = CCNT_W'(cfg.cols);
      end
      rows_m1 = rows_eff - RCNT_W'(1);
      cols_m1 = cols_eff - CCNT_W'(1);
      trow_c = ROW_W'((RC_W'(req.target_row) > RC_W'(rows_m1)) ?
                      RC_W'(rows_m1) : RC_W'(req.target_row));
      crow_c = ROW_W'((RC_W'(cur_row_ff) > RC_W'(rows_m1)) ?
                      RC_W'(rows_m1) : RC_W'(cur_row_ff));
      tcol_c = COL_W'((CC_W'(req.target_col) > CC_W'(cols_m1)) ?
                      CC_W'(cols_m1) : CC_W'(req.target_col));
      ccol_c = COL_W'((CC_W'(cur_col_ff) > CC_W'(cols_m1)) ?
                      CC_W'(cols_m1) : CC_W'(cur_col_ff));
   end

   assign taddr_c = ADDR_W'(MUL_W'(trow_c) * MUL_W'(cols_eff) + MUL_W'(tcol_c));
   assign caddr_c = ADDR_W'(MUL_W'(crow_c) * MUL_W'(cols_eff) + MUL_W'(ccol_c));
   assign area_c  = AREA_W'(AMUL_W'(rows_eff) * AMUL_W'(cols_eff));

   assign req.ready = (state_ff == S_IDLE) && !pend_ff;
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign blank     = {cfg.attr, CHAR_SPACE};

   // outcome of the latched action
   always_comb begin
      newline    = (ch_ff == CHAR_NEWLINE);
      wrap       = newline || (CC_W'(ccol_ff) + CC_W'(1) >= CC_W'(cols_eff));
      last_row   = (RC_W'(crow_ff) + RC_W'(1) >= RC_W'(rows_eff));
      scroll     = (act_ff == ACT_PUT) && wrap && last_row;
      need_sweep = scroll || (act_ff == ACT_CLEAR);

      cur_row_in = crow_ff;
      cur_col_in = ccol_ff;
      off_in     = AREA_W'(caddr_ff);
      unique case (act_ff)
         ACT_PUT: begin
            if (!wrap) begin
               cur_col_in = COL_W'(CC_W'(ccol_ff) + CC_W'(1));
               off_in     = AREA_W'(caddr_ff) + AREA_W'(1);
            end else if (!last_row) begin
               cur_row_in = ROW_W'(RC_W'(crow_ff) + RC_W'(1));
               cur_col_in = '0;
               off_in     = AREA_W'(caddr_ff) - AREA_W'(ccol_ff) + AREA_W'(cols_eff);
            end else begin
               cur_col_in = '0;
               off_in     = AREA_W'(caddr_ff) - AREA_W'(ccol_ff);
            end
         end
         ACT_CLEAR: begin
            cur_row_in = '0;
            cur_col_in = '0;
            off_in     = '0;
         end
         ACT_SET: begin
            cur_row_in = trow_ff;
            cur_col_in = tcol_ff;
            off_in     = AREA_W'(taddr_ff);
         end
         ACT_READ: begin
         end
      endcase

      if ((act_ff == ACT_PUT) && cfg.track) begin
         end_row_in = cur_row_in;
         end_col_in = cur_col_in;
      end else begin
         end_row_in = end_row_ff;
         end_col_in = end_col_ff;
      end

      res_in.cursor_row    = TROW_W'(cur_row_in);
      res_in.cursor_col    = TCOL_W'(cur_col_in);
      res_in.cursor_offset = OFFSET_W'(off_in);
      res_in.scrolled      = scroll;
      res_in.cell_value    = (act_ff == ACT_READ) ? mem_rdata : '0;
      res_in.typed_end_row = TROW_W'(end_row_in);
      res_in.typed_end_col = TCOL_W'(end_col_in);
   end

   // memory port steering; a pending sweep write never meets an execute write
   assign sweeping  = (state_ff == S_INIT) || (state_ff == S_SWEEP);
   assign copy      = sweeping && (AREA_W'(cnt_ff) < copy_lim_ff);
   assign exec_we   = (state_ff == S_EXEC) && (act_ff == ACT_PUT) && !newline &&
                      (need_sweep || out_free);
   assign mem_we    = pend_ff || exec_we;
   assign mem_waddr = pend_ff ? pend_addr_ff : caddr_ff;
   assign mem_wdata = pend_ff ? (pend_copy_ff ? mem_rdata : fill_ff) : {cfg.attr, ch_ff};
   assign mem_re    = (accept && (action_type'(req.action) == ACT_READ)) || copy;
   assign mem_raddr = copy ? ADDR_W'(AREA_W'(cnt_ff) + AREA_W'(cols_eff)) : taddr_c;

   // load the output register from execute or from the end of a sweep
   assign rsp_load  = ((state_ff == S_EXEC) && !need_sweep && out_free) ||
                      ((state_ff == S_DONE) && out_free);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         act_ff       <= ACT_PUT;
         cnt_ff       <= '0;
         last_ff      <= ADDR_W'(DEPTH - 1);
         copy_lim_ff  <= '0;
         fill_ff      <= RESET_CELL;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         end_row_ff   <= '0;
         end_col_ff   <= '0;
      end else begin
         pend_ff      <= sweeping;
         pend_addr_ff <= cnt_ff;
         pend_copy_ff <= copy;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT, S_SWEEP: begin
               cnt_ff <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == last_ff) begin
                  state_ff <= (state_ff == S_INIT) ? S_IDLE : S_DONE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  act_ff   <= action_type'(req.action);
                  ch_ff    <= req.char_code;
                  crow_ff  <= crow_c;
                  ccol_ff  <= ccol_c;
                  trow_ff  <= trow_c;
                  tcol_ff  <= tcol_c;
                  caddr_ff <= caddr_c;
                  taddr_ff <= taddr_c;
                  area_ff  <= area_c;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (need_sweep) begin
                  cur_row_ff  <= cur_row_in;
                  cur_col_ff  <= cur_col_in;
                  end_row_ff  <= end_row_in;
                  end_col_ff  <= end_col_in;
                  res_ff      <= res_in;
                  cnt_ff      <= '0;
                  copy_lim_ff <= scroll ? (area_ff - AREA_W'(cols_eff)) : '0;
                  last_ff     <= ADDR_W'(area_ff - AREA_W'(1));
                  fill_ff     <= blank;
                  state_ff    <= S_SWEEP;
               end else if (out_free) begin
                  cur_row_ff   <= cur_row_in;
                  cur_col_ff   <= cur_col_in;
                  end_row_ff   <= end_row_in;
                  end_col_ff   <= end_col_in;
                  rsp_ff       <= res_in;
                  state_ff     <= S_IDLE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_ff       <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_INIT;
            end
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.cursor_row    = rsp_ff.cursor_row;
   assign rsp.cursor_col    = rsp_ff.cursor_col;
   assign rsp.cursor_offset = rsp_ff.cursor_offset;
   assign rsp.scrolled      = rsp_ff.scrolled;
   assign rsp.cell_value    = rsp_ff.cell_value;
   assign rsp.typed_end_row = rsp_ff.typed_end_row;
   assign rsp.typed_end_col = rsp_ff.typed_end_col;

endmodule

// ===== src/text_console_writer_unit.sv =====
// Top level of the text console writer: register file and console engine.
//
//  channel | direction | contents
//  --------+-----------+-------------------------------------------------------
//  req_bus | in        | action, char_code, target_row, target_col
//  rsp_bus | out       | cursor row/col/offset, scrolled, cell value, input end
//  csr_*   | in        | write enable, register index, write data (no read-back)
//
// Put, set cursor and read cell pass through the transfer, where the cell
// address is formed and a read issues its memory read, and execute, where a put writes its cell.
// Clear and a put that scrolls sweep the area with the single memory write
// port, one cell a cycle.
// After reset a clearing pass writes all MAX_ROWS*MAX_COLS cells (4096 by
// default) with 0x0720; no request is taken meanwhile.
// The output register holds a result until its transfer; the next request is
// taken meanwhile, and its result holds in execute, or at the end of its sweep, until the register frees.
module text_console_writer_unit import tcw_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   tcw_req_if.sink                req_bus,
   tcw_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;

   // Register file: the user must write only while the engine is idle; the block does not
   // enforce it. The engine reads these directly with no shadow copy.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows  <= RESET_ROWS;
         cfg_ff.cols  <= RESET_COLS;
         cfg_ff.attr  <= RESET_ATTR;
         cfg_ff.track <= 1'b0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_ROWS:  cfg_ff.rows  <= csr_wdata[5:0];
            REG_COLS:  cfg_ff.cols  <= csr_wdata;
            REG_ATTR:  cfg_ff.attr  <= csr_wdata;
            REG_TRACK: cfg_ff.track <= csr_wdata[0];
         endcase
      end
   end

   // Engine: clamps sizes and positions, sequences actions, owns screen memory.
   tcw_engine #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule

// ===== dv/tcw_screen_compare.sv =====
// Shadow screen model of the text console writer that checks every response.
module tcw_screen_compare import tcw_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   tcw_req_if                     req_mon,
   tcw_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatches,
   output int unsigned            results_seen
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;

   logic [CELL_W-1:0] shadow_screen [CELLS];
   int unsigned       cur_row, cur_col, end_row, end_col;
   cfg_type           cfg;
   rsp_payload_type   awaited_status [$];
   int unsigned       fail_count;
   int unsigned       seen_count;

   function automatic int unsigned rows_in_use();
      if (cfg.rows == 0) return 1;
      return (cfg.rows > MAX_ROWS) ? MAX_ROWS : int'(cfg.rows);
   endfunction

   function automatic int unsigned cols_in_use();
      if (cfg.cols == 0) return 1;
      return (cfg.cols > MAX_COLS) ? MAX_COLS : int'(cfg.cols);
   endfunction

   // Move to column 0 of the next row; roll the screen up on the last row.
   function automatic bit feed_line(int unsigned rows, int unsigned cols);
      int unsigned i;
      bit          rolled;
      rolled = 1'b0;
      if (cur_row + 1 >= rows) begin
         for (i = 0; i < (rows - 1) * cols; i++)
            shadow_screen[i] = shadow_screen[i + cols];
         for (i = (rows - 1) * cols; i < rows * cols; i++)
            shadow_screen[i] = {cfg.attr, CHAR_SPACE};
         rolled = 1'b1;
      end else begin
         cur_row++;
      end
      cur_col = 0;
      return rolled;
   endfunction

   function automatic rsp_payload_type apply_console_action(action_type act,
         logic [CHAR_W-1:0] ch, logic [TROW_W-1:0] tr_in, logic [TCOL_W-1:0] tc_in);
      int unsigned     rows, cols, tr, tc, i;
      rsp_payload_type st;
      rows = rows_in_use();
      cols = cols_in_use();
      tr   = tr_in;
      tc   = tc_in;
      st   = '0;
      // clamp targets and a cursor left over from a larger screen
      if (tr > rows - 1) tr = rows - 1;
      if (tc > cols - 1) tc = cols - 1;
      if (cur_row > rows - 1) cur_row = rows - 1;
      if (cur_col > cols - 1) cur_col = cols - 1;
      case (act)
         ACT_PUT: begin
            if (ch == CHAR_NEWLINE) begin
               st.scrolled = feed_line(rows, cols);
            end else begin
               shadow_screen[cur_row * cols + cur_col] = {cfg.attr, ch};
               cur_col++;
               if (cur_col >= cols) st.scrolled = feed_line(rows, cols);
            end
            if (cfg.track) begin
               end_row = cur_row;
               end_col = cur_col;
            end
         end
         ACT_CLEAR: begin
            for (i = 0; i < rows * cols; i++) shadow_screen[i] = {cfg.attr, CHAR_SPACE};
            cur_row = 0;
            cur_col = 0;
         end
         ACT_SET: begin
            cur_row = tr;
            cur_col = tc;
         end
         default: st.cell_value = shadow_screen[tr * cols + tc];
      endcase
      st.cursor_row    = TROW_W'(cur_row);
      st.cursor_col    = TCOL_W'(cur_col);
      st.cursor_offset = OFFSET_W'(cur_row * cols + cur_col);
      st.typed_end_row = TROW_W'(end_row);
      st.typed_end_col = TCOL_W'(end_col);
      return st;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (fail_count < 200)
         $display("screen_compare: response %0d %s: got 0x%0h, expected 0x%0h",
                  seen_count, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         for (int k = 0; k < CELLS; k++) shadow_screen[k] = RESET_CELL;
         cur_row    = 0;
         cur_col    = 0;
         end_row    = 0;
         end_col    = 0;
         cfg        = '{rows: RESET_ROWS, cols: RESET_COLS, attr: RESET_ATTR, track: 1'b0};
         fail_count = 0;
         seen_count = 0;
         awaited_status.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_ROWS: cfg.rows  = csr_wdata[5:0];
               REG_COLS: cfg.cols  = csr_wdata;
               REG_ATTR: cfg.attr  = csr_wdata;
               default:  cfg.track = csr_wdata[0];
            endcase
         end
         // retire the oldest status before queuing a new one
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_status.size() == 0) begin
               report_mismatch("arrived with nothing awaited", 0, 0);
            end else begin
               want = awaited_status.pop_front();
               if (rsp_mon.cursor_row !== want.cursor_row)
                  report_mismatch("cursor_row", rsp_mon.cursor_row, want.cursor_row);
               if (rsp_mon.cursor_col !== want.cursor_col)
                  report_mismatch("cursor_col", rsp_mon.cursor_col, want.cursor_col);
               if (rsp_mon.cursor_offset !== want.cursor_offset)
                  report_mismatch("cursor_offset", rsp_mon.cursor_offset,
                                  want.cursor_offset);
               if (rsp_mon.scrolled !== want.scrolled)
                  report_mismatch("scrolled", rsp_mon.scrolled, want.scrolled);
               if (rsp_mon.cell_value !== want.cell_value)
                  report_mismatch("cell_value", rsp_mon.cell_value, want.cell_value);
               if (rsp_mon.typed_end_row !== want.typed_end_row)
                  report_mismatch("typed_end_row", rsp_mon.typed_end_row,
                                  want.typed_end_row);
               if (rsp_mon.typed_end_col !== want.typed_end_col)
                  report_mismatch("typed_end_col", rsp_mon.typed_end_col,
                                  want.typed_end_col);
            end
            seen_count++;
         end
         if (req_mon.valid && req_mon.ready)
            awaited_status.push_back(apply_console_action(action_type'(req_mon.action),
               req_mon.char_code, req_mon.target_row, req_mon.target_col));
      end
      mismatches   <= fail_count;
      results_seen <= seen_count;
   end

endmodule

// ===== dv/tb.sv =====
// Top of the text console writer testbench: clock, reset, stimulus and verdict.
module tb;
   import tcw_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 8_000_000;
   localparam int unsigned TARGET_ITEMS   = 1900;
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned TAIL_CYCLES    = 16;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CFG_INDEX_W-1:0] csr_index;
   logic [CFG_DATA_W-1:0]  csr_wdata;
   int unsigned            mismatches;
   int unsigned            results_seen;

   int unsigned items_sent     = 0;
   int unsigned burst_left     = 0;
   bit          sender_eager   = 1'b0;
   int unsigned holdoff_asked  = 0;
   int unsigned holdoff_served = 0;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_writer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tcw_screen_compare i_screen_compare (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .results_seen (results_seen)
   );

   always #10 clock = ~clock;

   // Offer one request and hold it until its transfer. Bursts of back-to-back
   // requests alternate with idle gaps; an eager phase never idles.
   task automatic offer_item(action_type act, logic [CHAR_W-1:0] ch,
                             logic [TROW_W-1:0] tr, logic [TCOL_W-1:0] tc);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (sender_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.char_code  <= ch;
      req_bus.target_row <= tr;
      req_bus.target_col <= tc;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      items_sent++;
   endtask

   // Drop valid and hold until every queued status has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (results_seen < items_sent) @(posedge clock);
   endtask

   // Write all four registers on consecutive edges; only while idle.
   task automatic write_config(logic [7:0] rows, logic [7:0] cols, logic [7:0] attr,
                               logic track);
      csr_we    <= 1'b1;
      csr_index <= REG_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= REG_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= REG_ATTR;
      csr_wdata <= attr;
      @(posedge clock);
      csr_index <= REG_TRACK;
      csr_wdata <= {7'd0, track};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Response side: stretches of full rate, random stalls and a sparse
   // pattern; a requested hold-off drops ready for a long counted stretch.
   initial begin : rsp_pacer
      int unsigned hold_left, stretch_left, mode, tick;
      hold_left    = 0;
      stretch_left = 0;
      mode         = 0;
      tick         = 0;
      forever begin
         if (holdoff_served != holdoff_asked) begin
            holdoff_served++;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               mode         = $urandom_range(0, 2);
               stretch_left = $urandom_range(10, 120);
            end
            stretch_left--;
            tick++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= (tick % 4 == 0);
            endcase
         end
         @(posedge clock);
      end
   end

   // Hard stop if the block hangs.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase, count, k, sel, put_pct, set_pct, clear_pct, nl_odds;
      int unsigned rows_span, cols_span;
      logic [7:0]  rows_cfg, cols_cfg, attr_cfg;
      logic        track_cfg, full_size;
      action_type  act;
      logic [CHAR_W-1:0] ch;
      logic [TROW_W-1:0] tr;
      logic [TCOL_W-1:0] tc;

      // Every input known from time zero; reset held at the start, then released.
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= REG_ROWS;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_PUT;
      req_bus.char_code  <= '0;
      req_bus.target_row <= '0;
      req_bus.target_col <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset size 25x80, extremes of every field, wrap on the last
      // row; requests just wait out the clearing pass after reset.
      offer_item(ACT_READ, 8'h00, 5'd31, 7'd127);   // target clamped to the corner
      offer_item(ACT_PUT, 8'h00, 5'd0, 7'd0);
      offer_item(ACT_PUT, 8'hff, 5'd31, 7'd127);
      offer_item(ACT_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
      offer_item(ACT_SET, 8'h00, 5'd31, 7'd127);    // clamped to the last cell
      offer_item(ACT_PUT, 8'h41, 5'd0, 7'd0);       // wraps and scrolls
      offer_item(ACT_READ, 8'h00, 5'd23, 7'd79);
      offer_item(ACT_READ, 8'h00, 5'd0, 7'd0);
      drain_responses();

      // Shrink to 2x3 with tracking on: the stale cursor gets clamped.
      write_config(8'd2, 8'd3, 8'hff, 1'b1);
      offer_item(ACT_PUT, 8'h62, 5'd0, 7'd0);
      offer_item(ACT_PUT, CHAR_NEWLINE, 5'd0, 7'd0);  // newline on the last row
      offer_item(ACT_PUT, 8'h63, 5'd0, 7'd0);
      offer_item(ACT_PUT, 8'h64, 5'd0, 7'd0);
      offer_item(ACT_PUT, 8'h65, 5'd0, 7'd0);
      offer_item(ACT_SET, 8'h00, 5'd0, 7'd1);
      offer_item(ACT_READ, 8'h00, 5'd0, 7'd0);
      offer_item(ACT_CLEAR, 8'h00, 5'd0, 7'd0);
      offer_item(ACT_READ, 8'h00, 5'd31, 7'd127);
      drain_responses();

      // Zero sizes act as a single cell: every put scrolls.
      write_config(8'd0, 8'd0, 8'h00, 1'b1);
      offer_item(ACT_PUT, 8'h7a, 5'd0, 7'd0);
      offer_item(ACT_READ, 8'h00, 5'd5, 7'd5);
      offer_item(ACT_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
      drain_responses();

      // Oversized values act as the full 32x128 screen.
      write_config(8'd63, 8'd255, 8'h5a, 1'b0);
      offer_item(ACT_SET, 8'h00, 5'd31, 7'd127);
      offer_item(ACT_PUT, 8'h7e, 5'd0, 7'd0);
      offer_item(ACT_READ, 8'h00, 5'd30, 7'd127);
      offer_item(ACT_CLEAR, 8'h00, 5'd0, 7'd0);
      offer_item(ACT_READ, 8'h00, 5'd31, 7'd127);
      drain_responses();

      // Random phases: mostly small screens so scrolls and clears stay cheap,
      // now and then a full-size one. Each phase ends with every status back.
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         full_size = (phase % 7 == 3);
         if (full_size) begin
            case ($urandom_range(0, 2))
               0:       rows_cfg = 8'd32;
               1:       rows_cfg = 8'd63;
               default: rows_cfg = 8'($urandom_range(20, 32));
            endcase
            case ($urandom_range(0, 2))
               0:       cols_cfg = 8'd128;
               1:       cols_cfg = 8'd255;
               default: cols_cfg = 8'($urandom_range(64, 200));
            endcase
            count     = 40;
            put_pct   = 45;
            set_pct   = 20;
            clear_pct = 2;
            nl_odds   = 16;
         end else begin
            rows_cfg  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
            cols_cfg  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 20));
            count     = (phase == 1) ? 160 : $urandom_range(60, 160);
            put_pct   = 60;
            set_pct   = 12;
            clear_pct = 4;
            nl_odds   = 8;
         end
         attr_cfg  = 8'($urandom_range(0, 255));
         track_cfg = 1'($urandom_range(0, 1));
         write_config(rows_cfg, cols_cfg, attr_cfg, track_cfg);

         // aim targets mostly inside the area in use
         rows_span = (rows_cfg == 0) ? 1 : ((rows_cfg > 32) ? 32 : rows_cfg);
         cols_span = (cols_cfg == 0) ? 1 : ((cols_cfg > 128) ? 128 : cols_cfg);

         // On one phase, stall responses long while requests keep coming so
         // the block backs up and stalls its input.
         sender_eager = (phase == 1) || ($urandom_range(0, 3) == 0);
         if (phase == 1) holdoff_asked++;

         for (k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < put_pct)                   act = ACT_PUT;
            else if (sel < put_pct + set_pct)    act = ACT_SET;
            else if (sel < 100 - clear_pct)      act = ACT_READ;
            else                                 act = ACT_CLEAR;
            ch = ($urandom_range(1, nl_odds) == 1) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
               tr = 5'($urandom_range(0, 31));
               tc = 7'($urandom_range(0, 127));
            end else begin
               tr = 5'($urandom_range(0, rows_span - 1));
               tc = 7'($urandom_range(0, cols_span - 1));
            end
            offer_item(act, ch, tr, tc);
         end
         drain_responses();
         phase++;
      end

      // Give a stray extra response time to show up, then judge.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && results_seen == items_sent) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
